/* rtl/tc8_pkg.sv */
`timescale 1ns / 1ps

package tc8_pkg;

    // request function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_CYCLE = 2'd2;
    localparam logic [1:0] FUNC_ACK   = 2'd3;

    // register map
    localparam logic [2:0] REG_CTRL_A = 3'd0;
    localparam logic [2:0] REG_CTRL_B = 3'd1;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_CMP_A  = 3'd3;
    localparam logic [2:0] REG_CMP_B  = 3'd4;
    localparam logic [2:0] REG_MASK   = 3'd5;
    localparam logic [2:0] REG_FLAGS  = 3'd6;
    localparam logic [2:0] REG_NONE   = 3'd7;

    // acknowledge sources
    localparam logic [1:0] ACK_OVF   = 2'd0;
    localparam logic [1:0] ACK_CMP_A = 2'd1;
    localparam logic [1:0] ACK_CMP_B = 2'd2;

    // flag bit positions
    localparam int FLAG_OVF   = 0;
    localparam int FLAG_CMP_A = 1;
    localparam int FLAG_CMP_B = 2;

    // waveform modes {ctrl_b[3], ctrl_a[1:0]}
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_PC_FF    = 3'd1;
    localparam logic [2:0] MODE_CTC      = 3'd2;
    localparam logic [2:0] MODE_FAST_FF  = 3'd3;
    localparam logic [2:0] MODE_PC_CMP   = 3'd5;
    localparam logic [2:0] MODE_FAST_CMP = 3'd7;

    // clock select codes
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;

    localparam logic [7:0] UNMAPPED_READ = 8'hFF;
    localparam logic [7:0] TOP_MAX       = 8'hFF;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [1:0] ack_source;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_overflow;
        logic       irq_compare_a;
        logic       irq_compare_b;
    } t_rsp;

endpackage

/* rtl/tc8_if.sv */
`timescale 1ns / 1ps

// request channel
interface tc8_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [1:0] ack_source;

    modport source (output valid, func, reg_index, write_data, ack_source, input ready);
    modport sink   (input valid, func, reg_index, write_data, ack_source, output ready);
endinterface

// response channel
interface tc8_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_overflow;
    logic       irq_compare_a;
    logic       irq_compare_b;

    modport source (output valid, read_data, irq_overflow, irq_compare_a, irq_compare_b,
                    input ready);
    modport sink   (input valid, read_data, irq_overflow, irq_compare_a, irq_compare_b,
                    output ready);
endinterface

/* rtl/tc8_in_stage.sv */
`timescale 1ns / 1ps

module tc8_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tc8_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_take,
    output tc8_pkg::t_req o_req
);
    import tc8_pkg::*;

    logic r_valid;
    t_req r_req;

    // register is free when empty or drained this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end
endmodule

/* rtl/tc8_core.sv */
`timescale 1ns / 1ps

module tc8_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_take,
    input  tc8_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output tc8_pkg::t_rsp o_rsp
);
    import tc8_pkg::*;

    // timer registers
    logic [7:0] r_ctrl_a, r_ctrl_b, r_count, r_cmp_a, r_cmp_b, r_mask;
    logic [2:0] r_flags;
    logic [9:0] r_presc;
    logic       r_up;
    logic [7:0] n_ctrl_a, n_ctrl_b, n_count, n_cmp_a, n_cmp_b, n_mask;
    logic [2:0] n_flags;
    logic [9:0] n_presc;
    logic       n_up;

    // output register
    logic r_out_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;

    logic [2:0]  mode;
    logic [7:0]  top;
    logic [10:0] presc_inc;
    logic [10:0] div;
    logic        tick;
    logic [7:0]  cnt_inc;
    logic [7:0]  cnt_dec;
    logic [7:0]  rd;

    assign o_take  = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    assign mode    = {r_ctrl_b[3], r_ctrl_a[1:0]};
    assign top     = (mode == MODE_CTC || mode == MODE_PC_CMP || mode == MODE_FAST_CMP)
                     ? r_cmp_a : TOP_MAX;
    assign cnt_inc = r_count + 8'd1;
    assign cnt_dec = r_count - 8'd1;
    assign presc_inc = {1'b0, r_presc} + 11'd1;

    // prescaler divisor; zero means the clock is stopped
    always_comb begin
        case (r_ctrl_b[2:0])
            CS_DIV1:    div = 11'd1;
            CS_DIV8:    div = 11'd8;
            CS_DIV64:   div = 11'd64;
            CS_DIV256:  div = 11'd256;
            CS_DIV1024: div = 11'd1024;
            default:    div = 11'd0;
        endcase
    end

    assign tick = (div != 11'd0) && (presc_inc >= div);

    // register read mux
    always_comb begin
        unique case (i_req.reg_index)
            REG_CTRL_A: rd = r_ctrl_a;
            REG_CTRL_B: rd = r_ctrl_b;
            REG_COUNT:  rd = r_count;
            REG_CMP_A:  rd = r_cmp_a;
            REG_CMP_B:  rd = r_cmp_b;
            REG_MASK:   rd = r_mask;
            REG_FLAGS:  rd = {5'd0, r_flags};
            default:    rd = UNMAPPED_READ;
        endcase
    end

    // next state for one request
    always_comb begin
        n_ctrl_a = r_ctrl_a;
        n_ctrl_b = r_ctrl_b;
        n_count  = r_count;
        n_cmp_a  = r_cmp_a;
        n_cmp_b  = r_cmp_b;
        n_mask   = r_mask;
        n_flags  = r_flags;
        n_presc  = r_presc;
        n_up     = r_up;

        unique case (i_req.func)
            FUNC_READ: begin
            end
            FUNC_WRITE: begin
                unique case (i_req.reg_index)
                    REG_CTRL_A: n_ctrl_a = i_req.write_data;
                    REG_CTRL_B: n_ctrl_b = i_req.write_data;
                    REG_COUNT: begin
                        n_count = i_req.write_data;
                        n_presc = '0;
                    end
                    REG_CMP_A:  n_cmp_a = i_req.write_data;
                    REG_CMP_B:  n_cmp_b = i_req.write_data;
                    REG_MASK:   n_mask  = i_req.write_data;
                    REG_FLAGS:  n_flags = r_flags & ~i_req.write_data[2:0];
                    default: begin
                    end
                endcase
            end
            FUNC_CYCLE: begin
                if (div != 11'd0) begin
                    n_presc = presc_inc[9:0] & (div[9:0] - 10'd1);
                end
                if (tick) begin
                    case (mode) inside
                        MODE_NORMAL, MODE_FAST_FF: begin
                            n_count = cnt_inc;
                            if (cnt_inc == r_cmp_a) n_flags[FLAG_CMP_A] = 1'b1;
                            if (cnt_inc == r_cmp_b) n_flags[FLAG_CMP_B] = 1'b1;
                            if (cnt_inc == 8'd0)    n_flags[FLAG_OVF]   = 1'b1;
                        end
                        MODE_CTC, MODE_FAST_CMP: begin
                            n_count = cnt_inc;
                            if (cnt_inc == r_cmp_a) n_flags[FLAG_CMP_A] = 1'b1;
                            if (cnt_inc == r_cmp_b) n_flags[FLAG_CMP_B] = 1'b1;
                            // count past top restarts from zero
                            if (cnt_inc > top) begin
                                n_count = 8'd0;
                                n_flags[FLAG_OVF] = 1'b1;
                            end
                        end
                        MODE_PC_FF, MODE_PC_CMP: begin
                            if (r_up) begin
                                n_count = cnt_inc;
                                if (cnt_inc == r_cmp_a) n_flags[FLAG_CMP_A] = 1'b1;
                                if (cnt_inc == r_cmp_b) n_flags[FLAG_CMP_B] = 1'b1;
                                if (cnt_inc >= top)     n_up = 1'b0;
                            end else begin
                                n_count = cnt_dec;
                                if (cnt_dec == r_cmp_a) n_flags[FLAG_CMP_A] = 1'b1;
                                if (cnt_dec == r_cmp_b) n_flags[FLAG_CMP_B] = 1'b1;
                                if (cnt_dec == 8'd0) begin
                                    n_up = 1'b1;
                                    n_flags[FLAG_OVF] = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                case (i_req.ack_source)
                    ACK_OVF:   n_flags[FLAG_OVF]   = 1'b0;
                    ACK_CMP_A: n_flags[FLAG_CMP_A] = 1'b0;
                    ACK_CMP_B: n_flags[FLAG_CMP_B] = 1'b0;
                    default: begin
                    end
                endcase
            end
        endcase

        // interrupt lines follow the updated state
        n_rsp.read_data     = (i_req.func == FUNC_READ) ? rd : 8'd0;
        n_rsp.irq_overflow  = n_mask[FLAG_OVF]   & n_flags[FLAG_OVF];
        n_rsp.irq_compare_a = n_mask[FLAG_CMP_A] & n_flags[FLAG_CMP_A];
        n_rsp.irq_compare_b = n_mask[FLAG_CMP_B] & n_flags[FLAG_CMP_B];
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
            r_ctrl_b <= '0;
            r_count  <= '0;
            r_cmp_a  <= '0;
            r_cmp_b  <= '0;
            r_mask   <= '0;
            r_flags  <= '0;
            r_presc  <= '0;
            r_up     <= 1'b1;
        end else if (o_take) begin
            r_ctrl_a <= n_ctrl_a;
            r_ctrl_b <= n_ctrl_b;
            r_count  <= n_count;
            r_cmp_a  <= n_cmp_a;
            r_cmp_b  <= n_cmp_b;
            r_mask   <= n_mask;
            r_flags  <= n_flags;
            r_presc  <= n_presc;
            r_up     <= n_up;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rsp <= n_rsp;
        end
    end
endmodule

/* rtl/timer_counter_8bit_pwm_top.sv */
`timescale 1ns / 1ps

// 8-bit timer/counter with prescaler, compare units and PWM waveform modes.
// Channels: i_req (sink) carries one request per item: a register read, a
// register write, one CPU clock cycle, or an interrupt acknowledge.
// o_rsp (source) returns exactly one response per request, in order: the
// read data (zero for anything but a read) and the three interrupt lines
// as they stand after the request took effect.
// Path: a request waits in the input register, then passes through the
// state update into the result register, which presents its response.
// Throughput: one request per cycle while o_rsp.ready stays high; the
// whole update of the timer state is one pass of logic between the input
// register and the result register.
// Reset (i_rst_n low at a clock edge) clears all timer registers, sets the
// counter direction to up, and empties both pipeline registers.
// When o_rsp.ready is low the response holds, one more request waits in
// the input register, and i_req.ready drops until the response is taken.
module timer_counter_8bit_pwm_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tc8_req_if.sink   i_req,
    tc8_rsp_if.source o_rsp
);
    import tc8_pkg::*;

    t_req req_in;
    t_req req_q;
    t_rsp rsp_q;
    logic req_q_valid;
    logic core_take;

    assign req_in.func       = i_req.func;
    assign req_in.reg_index  = i_req.reg_index;
    assign req_in.write_data = i_req.write_data;
    assign req_in.ack_source = i_req.ack_source;

    tc8_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_req   (req_in),
        .o_valid (req_q_valid),
        .i_take  (core_take),
        .o_req   (req_q)
    );

    tc8_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_q_valid),
        .o_take  (core_take),
        .i_req   (req_q),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_rsp   (rsp_q)
    );

    assign o_rsp.read_data     = rsp_q.read_data;
    assign o_rsp.irq_overflow  = rsp_q.irq_overflow;
    assign o_rsp.irq_compare_a = rsp_q.irq_compare_a;
    assign o_rsp.irq_compare_b = rsp_q.irq_compare_b;
endmodule
